// ===== rtl/lsac_pkg.sv =====
package lsac_pkg;

  // Item formats on the two channels.
  typedef struct packed {
    logic [15:0] start_angle_word;
    logic [15:0] end_angle_word;
    logic [7:0]  sample_count;
    logic [7:0]  sample_index;
    logic [15:0] raw_distance;
  } in_item_t;

  localparam int OUT_ANGLE_W = 21;

  typedef struct packed {
    logic [15:0]            distance_quarter_mm;
    logic [OUT_ANGLE_W-1:0] corrected_angle;
  } out_item_t;

  // Fixed formats.
  localparam int ANGLE_W        = 15;     // angle bits 15:1 of a raw word
  localparam int SPAN_W         = 17;     // signed span in 1/64 degree
  localparam int PROD_W         = 25;     // signed span times index
  localparam int CNT_W          = 8;
  localparam int DIST_W         = 16;
  localparam int FULL_TURN_64   = 23040;  // 360 degrees in 1/64 degree
  localparam int CORDIC_Q       = 24;
  localparam int ATAN_TABLE_LEN = 24;
  localparam int CORDIC_W       = 57;     // signed CORDIC x and y
  localparam int Z_W            = 32;     // signed angle accumulator, Q24 degrees
  localparam int X_GAIN         = 15530;
  localparam int Y_GAIN         = 218;
  localparam int Y_ZERO         = 6212;
  localparam int Y_SLOPE        = 10;
  localparam int XM_W           = 30;
  localparam int YL_W           = 21;
  localparam int YM_W           = 29;
  localparam int WRAP_STAGES    = 10;     // conditional subtracts of 512 .. 1 turns

  // Values the CORDIC stages carry alongside x, y and z.
  typedef struct packed {
    logic [ANGLE_W-1:0]       start_angle;
    logic signed [PROD_W-1:0] prod;
    logic [CNT_W-1:0]         count_m1;
    logic [DIST_W-1:0]        raw;
  } side_t;

  // atan(2^-i) in degrees, Q24.
  function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 32'sd754974720;
      5'd1:    v = 32'sd445687602;
      5'd2:    v = 32'sd235489088;
      5'd3:    v = 32'sd119537938;
      5'd4:    v = 32'sd60000934;
      5'd5:    v = 32'sd30029717;
      5'd6:    v = 32'sd15018523;
      5'd7:    v = 32'sd7509720;
      5'd8:    v = 32'sd3754917;
      5'd9:    v = 32'sd1877466;
      5'd10:   v = 32'sd938734;
      5'd11:   v = 32'sd469367;
      5'd12:   v = 32'sd234684;
      5'd13:   v = 32'sd117342;
      5'd14:   v = 32'sd58671;
      5'd15:   v = 32'sd29335;
      5'd16:   v = 32'sd14668;
      5'd17:   v = 32'sd7334;
      5'd18:   v = 32'sd3667;
      5'd19:   v = 32'sd1833;
      5'd20:   v = 32'sd917;
      5'd21:   v = 32'sd458;
      5'd22:   v = 32'sd229;
      5'd23:   v = 32'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/lsac_front.sv =====
module lsac_front (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  lsac_pkg::in_item_t                  item_i,
  output lsac_pkg::side_t                     side_o,
  output logic signed [lsac_pkg::CORDIC_W-1:0] x0_o,
  output logic signed [lsac_pkg::CORDIC_W-1:0] y0_o
);

  logic [lsac_pkg::ANGLE_W-1:0]       s_a, e_a;
  logic signed [lsac_pkg::SPAN_W-1:0] span;
  logic [lsac_pkg::XM_W-1:0]          xm;
  logic signed [lsac_pkg::YL_W-1:0]   ylin;
  logic signed [lsac_pkg::YM_W-1:0]   ym;
  lsac_pkg::side_t                    side_d;
  logic signed [lsac_pkg::CORDIC_W-1:0] x0_d, y0_d;

  always_comb begin
    s_a = item_i.start_angle_word[15:1];
    e_a = item_i.end_angle_word[15:1];
    // Going through 360 degrees when the start is above the end.
    if (s_a > e_a) begin
      span = lsac_pkg::SPAN_W'(lsac_pkg::FULL_TURN_64) - $signed({2'b00, s_a})
             + $signed({2'b00, e_a});
    end else begin
      span = $signed({2'b00, e_a}) - $signed({2'b00, s_a});
    end
    side_d.start_angle = s_a;
    side_d.prod = lsac_pkg::PROD_W'(span)
                  * lsac_pkg::PROD_W'($signed({1'b0, item_i.sample_index}));
    side_d.count_m1 = (item_i.sample_count == '0) ? '0 : item_i.sample_count - 8'd1;
    side_d.raw = item_i.raw_distance;

    xm = lsac_pkg::XM_W'(lsac_pkg::X_GAIN) * lsac_pkg::XM_W'(item_i.raw_distance);
    ylin = lsac_pkg::YL_W'(lsac_pkg::Y_ZERO)
           - $signed(lsac_pkg::YL_W'(lsac_pkg::Y_SLOPE * 32'(item_i.raw_distance)));
    ym = lsac_pkg::YM_W'(ylin) * lsac_pkg::YM_W'(lsac_pkg::Y_GAIN);
    x0_d = $signed(lsac_pkg::CORDIC_W'({xm, {lsac_pkg::CORDIC_Q{1'b0}}}));
    y0_d = lsac_pkg::CORDIC_W'($signed({ym, {lsac_pkg::CORDIC_Q{1'b0}}}));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_d;
      x0_o   <= x0_d;
      y0_o   <= y0_d;
    end
  end

endmodule

// ===== rtl/lsac_cordic.sv =====
module lsac_cordic #(
  parameter int ATAN_STAGES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [lsac_pkg::CORDIC_W-1:0] x0_i,
  input  logic signed [lsac_pkg::CORDIC_W-1:0] y0_i,
  input  lsac_pkg::side_t                      side_i,
  output logic signed [lsac_pkg::Z_W-1:0]      z_o,
  output lsac_pkg::side_t                      side_o
);

  localparam int ITER = (ATAN_STAGES < lsac_pkg::ATAN_TABLE_LEN) ? ATAN_STAGES
                                                                 : lsac_pkg::ATAN_TABLE_LEN;

  logic signed [lsac_pkg::CORDIC_W-1:0] x_q [ITER];
  logic signed [lsac_pkg::CORDIC_W-1:0] y_q [ITER];
  logic signed [lsac_pkg::Z_W-1:0]      z_q [ITER];
  lsac_pkg::side_t                      side_q [ITER];

  for (genvar i = 0; i < ITER; i++) begin : g_stage
    logic signed [lsac_pkg::CORDIC_W-1:0] x_in, y_in, x_d, y_d;
    logic signed [lsac_pkg::Z_W-1:0]      z_in, z_d;
    lsac_pkg::side_t                      side_in;

    if (i == 0) begin : g_first
      assign x_in    = x0_i;
      assign y_in    = y0_i;
      assign z_in    = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign x_in    = x_q[i-1];
      assign y_in    = y_q[i-1];
      assign z_in    = z_q[i-1];
      assign side_in = side_q[i-1];
    end

    // Rotate toward the x axis; arithmetic shifts floor negative values.
    always_comb begin
      if (!y_in[lsac_pkg::CORDIC_W-1]) begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + lsac_pkg::atan_q24(5'(i));
      end else begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - lsac_pkg::atan_q24(5'(i));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]    <= x_d;
        y_q[i]    <= y_d;
        z_q[i]    <= z_d;
        side_q[i] <= side_in;
      end
    end
  end

  assign z_o    = z_q[ITER-1];
  assign side_o = side_q[ITER-1];

endmodule

// ===== rtl/lsac_div.sv =====
module lsac_div #(
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [lsac_pkg::Z_W-1:0]    z_i,
  input  lsac_pkg::side_t                    side_i,
  output logic [ANGLE_FRAC_BITS+18:0]        q_o,
  output logic                               neg_o,
  output logic signed [ANGLE_FRAC_BITS+10:0] base_o,
  output logic [lsac_pkg::DIST_W-1:0]        raw_o
);

  localparam int SH     = ANGLE_FRAC_BITS - 6;
  localparam int MAG_W  = ANGLE_FRAC_BITS + 19;
  localparam int NUM_W  = lsac_pkg::PROD_W + SH + 2;
  localparam int BASE_W = ANGLE_FRAC_BITS + 11;
  localparam int CRW    = lsac_pkg::Z_W + 1 - (lsac_pkg::CORDIC_Q - ANGLE_FRAC_BITS);
  localparam int DEN_W  = lsac_pkg::CNT_W + 1;
  localparam int ZR_W   = lsac_pkg::Z_W + 1;

  logic signed [NUM_W-1:0] n_v, num;
  logic [lsac_pkg::CNT_W-1:0] den;
  logic signed [ZR_W-1:0]  zr;
  logic signed [CRW-1:0]   corr;
  logic                    neg_d;
  logic [MAG_W-1:0]        mag_d;
  logic signed [BASE_W-1:0] base_d;

  always_comb begin
    // A count of one or zero gives no interpolation: numerator 1, divisor 2.
    if (side_i.count_m1 == '0) begin
      den = lsac_pkg::CNT_W'(1);
      n_v = '0;
    end else begin
      den = side_i.count_m1;
      n_v = NUM_W'(side_i.prod) <<< SH;
    end
    num   = (n_v <<< 1) + $signed(NUM_W'(den));
    neg_d = num[NUM_W-1];
    // Floor of a negative quotient: divide the magnitude rounded up.
    if (neg_d) begin
      mag_d = MAG_W'(-num + $signed(NUM_W'({den, 1'b0})) - NUM_W'(1));
    end else begin
      mag_d = MAG_W'(num);
    end

    zr   = ZR_W'(z_i) + ZR_W'(1 << (lsac_pkg::CORDIC_Q - ANGLE_FRAC_BITS - 1));
    corr = CRW'(zr >>> (lsac_pkg::CORDIC_Q - ANGLE_FRAC_BITS));
    if (side_i.raw == '0) begin
      corr = '0;
    end
    base_d = ($signed(BASE_W'({1'b0, side_i.start_angle})) <<< SH) + BASE_W'(corr);
  end

  logic [MAG_W-1:0]          b_mag_q;
  logic [DEN_W-1:0]          b_den_q;
  logic                      b_neg_q;
  logic signed [BASE_W-1:0]  b_base_q;
  logic [lsac_pkg::DIST_W-1:0] b_raw_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_mag_q  <= mag_d;
      b_den_q  <= {den, 1'b0};
      b_neg_q  <= neg_d;
      b_base_q <= base_d;
      b_raw_q  <= side_i.raw;
    end
  end

  // Restoring division, one quotient bit per stage. The numerator leaves the
  // top of the work word as the quotient bits enter at the bottom.
  logic [MAG_W-1:0]            work_q [MAG_W];
  logic [DEN_W-1:0]            rem_q  [MAG_W];
  logic [DEN_W-1:0]            den_q  [MAG_W];
  logic                        neg_q  [MAG_W];
  logic signed [BASE_W-1:0]    base_q [MAG_W];
  logic [lsac_pkg::DIST_W-1:0] raw_q  [MAG_W];

  for (genvar j = 0; j < MAG_W; j++) begin : g_bit
    logic [MAG_W-1:0]            w_in;
    logic [DEN_W-1:0]            r_in, d_in, r_d;
    logic                        n_in;
    logic signed [BASE_W-1:0]    ba_in;
    logic [lsac_pkg::DIST_W-1:0] ra_in;
    logic [DEN_W:0]              trial;
    logic                        ge;

    if (j == 0) begin : g_first
      assign w_in  = b_mag_q;
      assign r_in  = '0;
      assign d_in  = b_den_q;
      assign n_in  = b_neg_q;
      assign ba_in = b_base_q;
      assign ra_in = b_raw_q;
    end else begin : g_next
      assign w_in  = work_q[j-1];
      assign r_in  = rem_q[j-1];
      assign d_in  = den_q[j-1];
      assign n_in  = neg_q[j-1];
      assign ba_in = base_q[j-1];
      assign ra_in = raw_q[j-1];
    end

    always_comb begin
      trial = {r_in, w_in[MAG_W-1]};
      ge    = (trial >= {1'b0, d_in});
      r_d   = ge ? DEN_W'(trial - {1'b0, d_in}) : DEN_W'(trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[j] <= {w_in[MAG_W-2:0], ge};
        rem_q[j]  <= r_d;
        den_q[j]  <= d_in;
        neg_q[j]  <= n_in;
        base_q[j] <= ba_in;
        raw_q[j]  <= ra_in;
      end
    end
  end

  assign q_o    = work_q[MAG_W-1];
  assign neg_o  = neg_q[MAG_W-1];
  assign base_o = base_q[MAG_W-1];
  assign raw_o  = raw_q[MAG_W-1];

endmodule

// ===== rtl/lsac_wrap.sv =====
module lsac_wrap #(
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [ANGLE_FRAC_BITS+18:0]        q_i,
  input  logic                               neg_i,
  input  logic signed [ANGLE_FRAC_BITS+10:0] base_i,
  input  logic [lsac_pkg::DIST_W-1:0]        raw_i,
  output lsac_pkg::out_item_t                item_o
);

  localparam int AW = ANGLE_FRAC_BITS + 20;
  localparam int NS = lsac_pkg::WRAP_STAGES;
  localparam logic [AW-1:0] FULL = AW'(lsac_pkg::FULL_TURN_64) << (ANGLE_FRAC_BITS - 6);
  localparam logic [AW-1:0] BIAS = FULL << (NS - 1);

  logic signed [AW:0] qs, sum;

  // The bias of 512 turns lifts every reachable angle above zero.
  always_comb begin
    qs  = neg_i ? -$signed((AW + 1)'({1'b0, q_i})) : $signed((AW + 1)'({1'b0, q_i}));
    sum = (AW + 1)'(base_i) + qs + $signed((AW + 1)'(BIAS) );
  end

  logic [AW-1:0]               c_ang_q;
  logic [lsac_pkg::DIST_W-1:0] c_raw_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_ang_q <= AW'(sum);
      c_raw_q <= raw_i;
    end
  end

  logic [AW-1:0]               ang_q [NS];
  logic [lsac_pkg::DIST_W-1:0] raw_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_turn
    localparam logic [AW-1:0] SUB = FULL << (NS - 1 - k);
    logic [AW-1:0]               a_in, a_d;
    logic [lsac_pkg::DIST_W-1:0] r_in;

    if (k == 0) begin : g_first
      assign a_in = c_ang_q;
      assign r_in = c_raw_q;
    end else begin : g_next
      assign a_in = ang_q[k-1];
      assign r_in = raw_q[k-1];
    end

    assign a_d = (a_in >= SUB) ? a_in - SUB : a_in;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ang_q[k] <= a_d;
        raw_q[k] <= r_in;
      end
    end
  end

  assign item_o.distance_quarter_mm = raw_q[NS-1];
  assign item_o.corrected_angle     = ang_q[NS-1][lsac_pkg::OUT_ANGLE_W-1:0];

endmodule

// ===== rtl/lidar_sample_angle_correct.sv =====
// Lidar sample angle correction. Each item is one sample of a triangulation
// lidar scan packet; the block interpolates the sample's angle between the
// packet's start and end angles (going through 360 degrees when the start is
// above the end), adds the range-dependent triangulation correction found by
// a pipelined CORDIC arctangent, wraps the result into [0, 360) and emits it
// in 1/2^ANGLE_FRAC_BITS degree together with the unchanged distance. The
// block accepts one item every cycle while the skid register is empty. The
// pipeline has one input stage, the CORDIC stages, the divider setup stage,
// one stage per quotient bit of the interpolation divider, the sum stage and
// the ten stages of the turn reduction. A two-entry output (pipeline end plus
// skid register) lets a finished item that is not taken park in the skid
// register while the pipeline advances; the input is stalled only while the
// skid register holds an item.
module lidar_sample_angle_correct #(
  parameter int ANGLE_FRAC_BITS = 12,
  parameter int ATAN_STAGES     = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lsac_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lsac_pkg::out_item_t out_item_o
);

  localparam int ITER  = (ATAN_STAGES < lsac_pkg::ATAN_TABLE_LEN) ? ATAN_STAGES
                                                                  : lsac_pkg::ATAN_TABLE_LEN;
  localparam int MAG_W = ANGLE_FRAC_BITS + 19;
  // Input stage, CORDIC, divider setup and bits, sum stage, turn reduction.
  localparam int N_ST  = 1 + ITER + 1 + MAG_W + 1 + lsac_pkg::WRAP_STAGES;

  // The whole pipeline moves together unless the skid register is occupied.
  logic en;
  logic [N_ST-1:0] v_q;
  logic skid_v_q, skid_v_d;
  lsac_pkg::out_item_t skid_q, pipe_item;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[N_ST-2:0], in_valid_i};
    end
  end

  // Datapath.
  lsac_pkg::side_t                      f_side, c_side;
  logic signed [lsac_pkg::CORDIC_W-1:0] x0, y0;
  logic signed [lsac_pkg::Z_W-1:0]      z;
  logic [MAG_W-1:0]                     q;
  logic                                 q_neg;
  logic signed [ANGLE_FRAC_BITS+10:0]   base;
  logic [lsac_pkg::DIST_W-1:0]          d_raw;

  lsac_front u_front (
    .clk_i  (clk_i),
    .en_i   (en),
    .item_i (in_item_i),
    .side_o (f_side),
    .x0_o   (x0),
    .y0_o   (y0)
  );

  lsac_cordic #(
    .ATAN_STAGES (ATAN_STAGES)
  ) u_cordic (
    .clk_i  (clk_i),
    .en_i   (en),
    .x0_i   (x0),
    .y0_i   (y0),
    .side_i (f_side),
    .z_o    (z),
    .side_o (c_side)
  );

  lsac_div #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .z_i    (z),
    .side_i (c_side),
    .q_o    (q),
    .neg_o  (q_neg),
    .base_o (base),
    .raw_o  (d_raw)
  );

  lsac_wrap #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_wrap (
    .clk_i  (clk_i),
    .en_i   (en),
    .q_i    (q),
    .neg_i  (q_neg),
    .base_i (base),
    .raw_i  (d_raw),
    .item_o (pipe_item)
  );

  // When the last stage holds an item that is not taken while the pipeline
  // moves, that item parks in the skid register. The skid item is older than
  // whatever the last stage holds, so it is presented first.
  always_comb begin
    skid_v_d = skid_v_q;
    if (skid_v_q && !out_stall_i) begin
      skid_v_d = 1'b0;
    end else if (en && v_q[N_ST-1] && out_stall_i) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v_q[N_ST-1] && out_stall_i) begin
      skid_q <= pipe_item;
    end
  end

  assign out_valid_o = skid_v_q || v_q[N_ST-1];
  assign out_item_o  = skid_v_q ? skid_q : pipe_item;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

// Block-level testbench for lidar_sample_angle_correct.
//
// What it does:
// - A short table of directed samples runs first. It covers the field
//   extremes, a zero count, an index at or beyond the count, a start angle
//   above 360 degrees, a wrap through 360 degrees, zero distance and the
//   distance where the correction changes sign.
// - Random scan packets follow. Each packet is a run of samples with indices
//   0 .. count-1. A few broken packets are mixed in.
// - Every accepted item gets its expected result from the angle predictor
//   below. A directed row may give its expected result directly instead.
// - Results are checked in order, field by field.
//
// Both channels idle at random. The input side leaves gaps and the output
// side stalls. There are also long stretches with no gaps at all.
module tb_top;

  localparam int FRAC_BITS    = 12;
  localparam int CORDIC_STEPS = 16;
  localparam int LATENCY      = 60;
  localparam int NUM_ITEMS    = 750;

  // atan(2^-i) in degrees, Q24, used by the predictor's own CORDIC.
  localparam longint ATAN_DEG_Q24 [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  typedef struct {
    lsac_pkg::in_item_t  sample;
    bit                  has_exp;
    lsac_pkg::out_item_t exp;
  } sample_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  lsac_pkg::in_item_t  in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  lsac_pkg::out_item_t out_item_o;

  lsac_pkg::out_item_t expected_angles [$];
  int        mismatch_count;
  int        items_sent;
  int        results_seen;
  bit        quiet_phase;

  lidar_sample_angle_correct #(
    .ANGLE_FRAC_BITS(FRAC_BITS),
    .ATAN_STAGES    (CORDIC_STEPS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Triangulation correction in 2^-FRAC_BITS degree.
  // A vectoring CORDIC on x = 15530*r and y = 218*(6212-10*r), both in Q24.
  // The Q24 angle is then rounded, with ties going toward +infinity.
  function automatic longint range_offset(longint raw);
    longint x, y, z, xs, ys;
    if (raw == 0) return 0;
    x = (15530 * raw) <<< 24;
    y = (218 * (6212 - 10 * raw)) <<< 24;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_DEG_Q24[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_DEG_Q24[i];
      end
    end
    return (z + (64'sd1 <<< (23 - FRAC_BITS))) >>> (24 - FRAC_BITS);
  endfunction

  // Interpolated and corrected angle of one sample, wrapped to [0, 360).
  function automatic lsac_pkg::out_item_t predict_angle(lsac_pkg::in_item_t smp);
    longint s, e, cnt, idx, span, num, den, offset, full, angle;
    lsac_pkg::out_item_t res;
    s     = longint'(smp.start_angle_word[15:1]);
    e     = longint'(smp.end_angle_word[15:1]);
    cnt   = longint'(smp.sample_count);
    idx   = longint'(smp.sample_index);
    full  = longint'(lsac_pkg::FULL_TURN_64) <<< (FRAC_BITS - 6);
    span  = (s > e) ? (lsac_pkg::FULL_TURN_64 - s + e) : (e - s);
    offset = 0;
    if (cnt > 1) begin
      // Round to nearest with ties going up. This is a floor division of
      // (2n + d) by 2d.
      den = 2 * (cnt - 1);
      num = 2 * ((span * idx) <<< (FRAC_BITS - 6)) + (cnt - 1);
      offset = num / den;
      if ((num % den) != 0 && num < 0) offset = offset - 1;
    end
    angle = (s <<< (FRAC_BITS - 6)) + offset
          + range_offset(longint'(smp.raw_distance));
    angle = angle % full;
    if (angle < 0) angle = angle + full;
    res.distance_quarter_mm = smp.raw_distance;
    res.corrected_angle     = angle[lsac_pkg::OUT_ANGLE_W-1:0];
    return res;
  endfunction

  // Input side gap: mostly zero, sometimes short and rarely long.
  // No gaps are left during a quiet phase.
  function automatic int pick_gap();
    if (quiet_phase || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Drive one item and hold it until the block takes it. The expectation
  // is queued at the edge where the item is accepted.
  task automatic send_sample(lsac_pkg::in_item_t smp, bit has_exp,
                             lsac_pkg::out_item_t exp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= smp;
    do @(posedge clk_i); while (in_stall_o);
    expected_angles.push_back(has_exp ? exp : predict_angle(smp));
    items_sent++;
  endtask

  // Random distance: mostly full range, with zero and short ranges common.
  // Short ranges are where the correction is largest.
  function automatic logic [15:0] pick_distance();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'($urandom_range(1, 700));
      default: return 16'($urandom);
    endcase
  endfunction

  // Output stall: runs of free and stalled cycles chosen at random, with an
  // occasional long run. No new stall run starts in a quiet phase.
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (quiet_phase) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_left  <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 3);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_angles.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result dist=%0d angle=%0d",
                   out_item_o.distance_quarter_mm, out_item_o.corrected_angle);
      end else begin
        lsac_pkg::out_item_t exp;
        exp = expected_angles.pop_front();
        if (out_item_o.distance_quarter_mm !== exp.distance_quarter_mm ||
            out_item_o.corrected_angle !== exp.corrected_angle) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result %0d exp dist=%0d angle=%0d got dist=%0d angle=%0d",
                     results_seen, exp.distance_quarter_mm, exp.corrected_angle,
                     out_item_o.distance_quarter_mm, out_item_o.corrected_angle);
        end
      end
    end
  end

  // Directed samples. An expected value is given only where it is obvious
  // at a glance: zero distance and a count of zero or one, so the result
  // is the start angle times 64, wrapped to one turn.
  sample_row_t directed_rows [14];
  initial begin
    directed_rows = '{
      '{'{16'h0000, 16'h0000, 8'd1,   8'd0,   16'd0},     1'b1, '{16'd0, 21'd0}},
      '{'{16'hFFFF, 16'h0000, 8'd1,   8'd0,   16'd0},     1'b1, '{16'd0, 21'd622528}},
      '{'{16'h0001, 16'h0001, 8'd1,   8'd0,   16'd0},     1'b1, '{16'd0, 21'd0}},
      '{'{16'h0100, 16'hFFFF, 8'd0,   8'd7,   16'd0},     1'b1, '{16'd0, 21'd8192}},
      '{'{16'h0000, 16'h0000, 8'd1,   8'd0,   16'hFFFF},  1'b0, '{16'd0, 21'd0}},
      '{'{16'h0000, 16'h0000, 8'd1,   8'd0,   16'd1},     1'b0, '{16'd0, 21'd0}},
      '{'{16'd44000, 16'd2000, 8'd10, 8'd9,   16'd1000},  1'b0, '{16'd0, 21'd0}},
      '{'{16'd44000, 16'd2000, 8'd10, 8'd4,   16'd0},     1'b0, '{16'd0, 21'd0}},
      '{'{16'h0000, 16'hFFFE, 8'd255, 8'd254, 16'd4000},  1'b0, '{16'd0, 21'd0}},
      '{'{16'h0000, 16'hFFFF, 8'd255, 8'd255, 16'd4000},  1'b0, '{16'd0, 21'd0}},
      '{'{16'd1000, 16'd3000, 8'd5,   8'd200, 16'd300},   1'b0, '{16'd0, 21'd0}},
      '{'{16'd1000, 16'd3000, 8'd2,   8'd1,   16'd621},   1'b0, '{16'd0, 21'd0}},
      '{'{16'd1000, 16'd3000, 8'd2,   8'd0,   16'd622},   1'b0, '{16'd0, 21'd0}},
      '{'{16'hAAAA, 16'h5555, 8'hAA,  8'h55,  16'h5555},  1'b0, '{16'd0, 21'd0}}
    };
  end

  initial begin
    lsac_pkg::in_item_t  smp;
    lsac_pkg::out_item_t none;
    int        cnt;
    int        wait_cycles;
    logic [15:0] s_word, e_word;
    none           = '0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    quiet_phase    = 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    results_seen   = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r])
      send_sample(directed_rows[r].sample, directed_rows[r].has_exp,
                  directed_rows[r].exp);

    // Random packets. Most are well formed. About one in eight uses a
    // random count and index, which covers a zero count and an index
    // past the end.
    while (items_sent < NUM_ITEMS) begin
      quiet_phase = ($urandom_range(0, 5) == 0);
      s_word = 16'($urandom);
      e_word = 16'($urandom);
      if ($urandom_range(0, 7) == 0) begin
        smp = '{s_word, e_word, 8'($urandom), 8'($urandom), pick_distance()};
        send_sample(smp, 1'b0, none);
      end else begin
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255)
                                          : $urandom_range(1, 24);
        for (int k = 0; k < cnt && items_sent < NUM_ITEMS; k++) begin
          smp = '{s_word, e_word, 8'(cnt), 8'(k), pick_distance()};
          send_sample(smp, 1'b0, none);
        end
      end
    end
    in_valid_i <= 1'b0;
    quiet_phase = 1'b0;

    wait_cycles = 0;
    while (expected_angles.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("Sent %0d samples (directed extremes, then random scan packets);",
             items_sent);
    $display("checked %0d results, %0d mismatches, %0d still expected.",
             results_seen, mismatch_count, expected_angles.size());
    if (mismatch_count == 0 && expected_angles.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Timeout: run did not finish.");
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
